>>> design/stsum_pkg.sv
// Shared constants for the segment tree range sum block.
// Field widths and operation codes; no dependencies.
package stsum_pkg;

   // Input field widths
   localparam int POS_W = 10;
   localparam int VAL_W = 64;

   // Operation codes carried by req_cmd
   localparam logic CMD_SET   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

endpackage

>>> design/stsum_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stsum_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/segment_tree_range_sum_top.sv
// Segment tree range sum: point set and inclusive range query over LEAF_COUNT leaves.
// Set: accept writes the leaf and fetches its sibling, then each level writes the parent.
// Query: walks the tree level by level, with an extra step on each level where both range
// ends are odd (ST_QHI), then posts the sum to the result register.
// One item in flight; a query ends only once the previous result beat has been taken.
// Reset: clearing pass over all 2*LEAF_COUNT nodes, req_ready low. Uses stsum_pkg and stsum_ram.
module segment_tree_range_sum_top #(
   parameter int unsigned LEAF_COUNT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [stsum_pkg::POS_W-1:0]         req_position,
   input  logic signed [stsum_pkg::VAL_W-1:0]  req_new_value,
   input  logic [stsum_pkg::POS_W-1:0]         req_range_first,
   input  logic [stsum_pkg::POS_W-1:0]         req_range_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [stsum_pkg::VAL_W-1:0]  rsp_range_sum
);

   import stsum_pkg::*;

   localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT;
   localparam int AW = $clog2(NODE_COUNT);
   // node bounds of a query reach NODE_COUNT itself
   localparam int NW = AW + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_QUERY,
      ST_QHI
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [AW-1:0]    node_ff, node_in;
   logic [VAL_W-1:0] cur_ff, cur_in;
   logic [NW-1:0]    lo_ff, lo_in;
   logic [NW-1:0]    hi_ff, hi_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic             rvalid_ff, rvalid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [VAL_W-1:0] wr_data;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [VAL_W-1:0] rd_data;

   logic [VAL_W-1:0] acc_sum;
   logic [VAL_W-1:0] up_sum;
   logic [AW-1:0]    parent;
   logic [AW-1:0]    leaf;
   logic [NW-1:0]    hi_dec;
   logic [31:0]      pos_ext;
   logic [31:0]      first_ext;
   logic [31:0]      last_ext;
   logic [31:0]      last_clip;

   // Node memory: node 1 is the root, leaf p sits at node LEAF_COUNT+p
   stsum_ram #(
      .WIDTH(VAL_W),
      .DEPTH(NODE_COUNT)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Datapath helpers
   assign acc_sum   = acc_ff + (rvalid_ff ? rd_data : '0);
   assign up_sum    = cur_ff + rd_data;
   assign parent    = node_ff >> 1;
   assign hi_dec    = hi_ff - NW'(1);
   assign pos_ext   = 32'(req_position);
   assign first_ext = 32'(req_range_first);
   assign last_ext  = 32'(req_range_last);
   assign last_clip = (last_ext >= LEAF_COUNT) ? (LEAF_COUNT - 32'd1) : last_ext;
   assign leaf      = AW'(LEAF_COUNT + pos_ext);

   // Sequencer: clear pass, leaf-to-root update, level-by-level query walk
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      acc_in       = acc_ff;
      rvalid_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      // result beat taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            if (clr_addr_ff == AW'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_SET: begin
                     // positions beyond the leaves leave the tree alone
                     if (pos_ext < LEAF_COUNT) begin
                        wr_en     = 1'b1;
                        wr_addr   = leaf;
                        wr_data   = req_new_value;
                        rd_en     = 1'b1;
                        rd_addr   = leaf ^ AW'(1);
                        node_in   = leaf;
                        cur_in    = req_new_value;
                        state_in  = ST_UPDATE;
                     end
                  end
                  CMD_QUERY: begin
                     acc_in   = '0;
                     state_in = ST_QUERY;
                     if (first_ext > last_clip) begin
                        // empty range: walk ends at once with zero
                        lo_in = '0;
                        hi_in = '0;
                     end else begin
                        lo_in = NW'(LEAF_COUNT + first_ext);
                        hi_in = NW'(LEAF_COUNT + last_clip + 32'd1);
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_UPDATE: begin
            // sibling arrived: write the parent, fetch the parent's sibling
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = up_sum;
            cur_in  = up_sum;
            node_in = parent;
            if (parent > AW'(1)) begin
               rd_en   = 1'b1;
               rd_addr = parent ^ AW'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_QUERY: begin
            acc_in = acc_sum;
            if (lo_ff >= hi_ff) begin
               // last read data is folded in through acc_sum
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = acc_sum;
                  state_in     = ST_IDLE;
               end
            end else if (lo_ff[0] && hi_ff[0]) begin
               rd_en     = 1'b1;
               rd_addr   = lo_ff[AW-1:0];
               rvalid_in = 1'b1;
               lo_in     = lo_ff + NW'(1);
               state_in  = ST_QHI;
            end else if (lo_ff[0]) begin
               rd_en     = 1'b1;
               rd_addr   = lo_ff[AW-1:0];
               rvalid_in = 1'b1;
               lo_in     = (lo_ff + NW'(1)) >> 1;
               hi_in     = hi_ff >> 1;
            end else if (hi_ff[0]) begin
               rd_en     = 1'b1;
               rd_addr   = hi_dec[AW-1:0];
               rvalid_in = 1'b1;
               lo_in     = lo_ff >> 1;
               hi_in     = hi_dec >> 1;
            end else begin
               lo_in = lo_ff >> 1;
               hi_in = hi_ff >> 1;
            end
         end

         ST_QHI: begin
            // right edge of a level where both ends were odd
            acc_in    = acc_sum;
            rd_en     = 1'b1;
            rd_addr   = hi_dec[AW-1:0];
            rvalid_in = 1'b1;
            lo_in     = lo_ff >> 1;
            hi_in     = hi_dec >> 1;
            state_in  = ST_QUERY;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = $signed(rsp_sum_ff);

endmodule

>>> tb/tb_segment_tree_range_sum_top.sv
`timescale 1ns / 100ps
// Testbench for segment_tree_range_sum_top: point sets and range-sum queries checked
// against a behavioral segment tree kept in the bench. Depends on stsum_pkg and the RTL.
module tb_segment_tree_range_sum_top;
   import stsum_pkg::*;

   localparam int unsigned LEAF_COUNT  = 1024;
   localparam int          RAND_ITEMS  = 380;
   localparam int          HOLD_CYCLES = 300;
   // the clearing pass and the long receiver hold both fit well inside this
   localparam int          STALL_LIMIT = 10000;
   localparam int          DRAIN_CYCLES = 40;

   localparam logic [VAL_W-1:0] MAX_V = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VAL_W-1:0] MIN_V = 64'h8000_0000_0000_0000;
   localparam logic [VAL_W-1:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_cmd;
   logic [POS_W-1:0]        req_position;
   logic signed [VAL_W-1:0] req_new_value;
   logic [POS_W-1:0]        req_range_first;
   logic [POS_W-1:0]        req_range_last;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_range_sum;

   // one row of the directed plan; typed rows carry their own expected sum
   typedef struct packed {
      logic             cmd;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] new_value;
      logic [POS_W-1:0] range_first;
      logic [POS_W-1:0] range_last;
      logic             typed;
      logic [VAL_W-1:0] sum;
   } plan_row_type;

   localparam int PLAN_ROWS = 22;
   plan_row_type plan [PLAN_ROWS];

   // bench copy of the tree: node 1 is the root, leaf p at LEAF_COUNT+p
   logic [VAL_W-1:0] node_sum [2*LEAF_COUNT];
   logic [VAL_W-1:0] pending_sums [$];
   int               fail_count;
   int               hold_requests;
   bit               no_idle;

   segment_tree_range_sum_top #(.LEAF_COUNT(LEAF_COUNT)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_position    (req_position),
      .req_new_value   (req_new_value),
      .req_range_first (req_range_first),
      .req_range_last  (req_range_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_sum   (rsp_range_sum)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // write one leaf and refresh its ancestors
   function automatic void tree_set_leaf(int unsigned pos, logic [VAL_W-1:0] value);
      int unsigned n;
      if (pos >= LEAF_COUNT) return;
      n = LEAF_COUNT + pos;
      node_sum[n] = value;
      while (n > 1) begin
         n = n >> 1;
         node_sum[n] = node_sum[2*n] + node_sum[2*n+1];
      end
   endfunction

   // inclusive range sum from the minimal covering nodes, wrapping
   function automatic logic [VAL_W-1:0] tree_range_sum(int unsigned first, int unsigned last);
      int unsigned      lo;
      int unsigned      hi;
      logic [VAL_W-1:0] acc;
      acc = '0;
      if (last >= LEAF_COUNT) last = LEAF_COUNT - 1;
      if (first > last) return acc;
      lo = LEAF_COUNT + first;
      hi = LEAF_COUNT + last + 1;
      while (lo < hi) begin
         if (lo[0]) begin
            acc = acc + node_sum[lo];
            lo++;
         end
         if (hi[0]) begin
            hi--;
            acc = acc + node_sum[hi];
         end
         lo = lo >> 1;
         hi = hi >> 1;
      end
      return acc;
   endfunction

   // mix of extremes, small signed values and full-width noise
   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 6))
         0: return MAX_V;
         1: return MIN_V;
         2: return ONES;
         3: return 64'(signed'($urandom_range(0, 200)) - 32'sd100);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offer one beat; entered and left at a falling edge. Prediction happens at the
   // accepting edge.
   task automatic offer_item(input logic cmd, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] value, input logic [POS_W-1:0] first,
                             input logic [POS_W-1:0] last, input logic typed,
                             input logic [VAL_W-1:0] typed_sum, input int gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd         = cmd;
      req_position    = pos;
      req_new_value   = value;
      req_range_first = first;
      req_range_last  = last;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_SET) tree_set_leaf(32'(pos), value);
      else if (typed) pending_sums.push_back(typed_sum);
      else pending_sums.push_back(tree_range_sum(32'(first), 32'(last)));
      @(negedge clock);
   endtask

   // result side: check each beat, then draw a stall or serve a long hold
   initial begin : rsp_side
      int               stall_left;
      int               hold_left;
      int               holds_seen;
      logic [VAL_W-1:0] want;
      stall_left = 0;
      hold_left  = 0;
      holds_seen = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_sums.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result %h with none expected", $realtime, rsp_range_sum);
            end else begin
               want = pending_sums.pop_front();
               if (rsp_range_sum !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: range_sum expected %h got %h", $realtime, want,
                              rsp_range_sum);
               end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // end the run if neither channel moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("segment_tree_range_sum_top: mismatch");
      $finish;
   end

   // reset, directed plan, random traffic, drain
   initial begin : stimulus
      int               press_left;
      int               gap;
      int unsigned      win_lo;
      int unsigned      a;
      int unsigned      b;
      logic             cmd;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] first;
      logic [POS_W-1:0] last;
      logic [VAL_W-1:0] value;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_SET;
      req_position    = '0;
      req_new_value   = '0;
      req_range_first = '0;
      req_range_last  = '0;
      fail_count      = 0;
      hold_requests   = 0;
      no_idle         = 1'b0;
      press_left      = 0;
      for (int n = 0; n < 2*LEAF_COUNT; n++) node_sum[n] = '0;

      plan = '{
         // empty tree, full range and reversed range
         '{CMD_QUERY, 10'd0,    64'd0, 10'd0,    10'd1023, 1'b1, 64'd0},
         '{CMD_QUERY, 10'd1023, ONES,  10'd1023, 10'd0,    1'b1, 64'd0},
         // extremes at both ends; range fields of a set are don't-care
         '{CMD_SET,   10'd0,    MAX_V, 10'd1023, 10'd0,    1'b0, 64'd0},
         '{CMD_SET,   10'd1023, MIN_V, 10'd0,    10'd1023, 1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd0,    10'd0,    1'b1, MAX_V},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd1023, 10'd1023, 1'b1, MIN_V},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd0,    10'd1023, 1'b1, ONES},
         // wrap on overflow
         '{CMD_SET,   10'd1,    MAX_V, 10'd0,    10'd0,    1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd0,    10'd1,    1'b1, 64'hFFFF_FFFF_FFFF_FFFE},
         // reversed range with set fields loaded
         '{CMD_QUERY, 10'd5,    MAX_V, 10'd1,    10'd0,    1'b1, 64'd0},
         // values that cancel across the tree midpoint
         '{CMD_SET,   10'd512,  ONES,  10'd0,    10'd0,    1'b0, 64'd0},
         '{CMD_SET,   10'd511,  64'd1, 10'd0,    10'd0,    1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd511,  10'd512,  1'b1, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd500,  10'd600,  1'b0, 64'd0},
         // overwrite a leaf
         '{CMD_SET,   10'd0,    64'd0, 10'd0,    10'd0,    1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd0,    10'd1,    1'b1, MAX_V},
         '{CMD_SET,   10'd1023, 64'h5555_5555_5555_5555, 10'd0, 10'd0, 1'b0, 64'd0},
         // odd/even range ends
         '{CMD_QUERY, 10'd0,    64'd0, 10'd1022, 10'd1023, 1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd1,    10'd1022, 1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd3,    10'd1020, 1'b0, 64'd0},
         '{CMD_SET,   10'd1,    64'd0, 10'd0,    10'd0,    1'b0, 64'd0},
         '{CMD_QUERY, 10'd0,    64'd0, 10'd0,    10'd1023, 1'b0, 64'd0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[r])
         offer_item(plan[r].cmd, plan[r].position, plan[r].new_value, plan[r].range_first,
                    plan[r].range_last, plan[r].typed, plan[r].sum, $urandom_range(0, 5));

      win_lo = $urandom_range(0, LEAF_COUNT - 64);
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 100 == 0) win_lo = $urandom_range(0, LEAF_COUNT - 64);
         // receiver holds off while queries keep coming: input must back up
         if (i == 100) begin
            hold_requests++;
            press_left = 20;
         end
         // sender waits for the block to drain completely
         if (i == 200) begin
            req_valid = 1'b0;
            while (pending_sums.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         no_idle = (i >= 250 && i < 300);

         pos   = POS_W'($urandom);
         value = pick_value();
         first = POS_W'($urandom);
         last  = POS_W'($urandom);
         cmd   = (press_left > 0 || $urandom_range(0, 99) < 55) ? CMD_QUERY : CMD_SET;
         if (cmd == CMD_SET) begin
            if ($urandom_range(0, 1)) pos = POS_W'(win_lo + $urandom_range(0, 63));
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  a = $urandom_range(1, LEAF_COUNT - 1);
                  first = POS_W'(a);
                  last  = POS_W'($urandom_range(0, a - 1));
               end
               1: begin
                  first = '0;
                  last  = POS_W'(LEAF_COUNT - 1);
               end
               2: last = first;
               3, 4, 5: begin
                  a = win_lo + $urandom_range(0, 63);
                  b = win_lo + $urandom_range(0, 63);
                  first = POS_W'((a < b) ? a : b);
                  last  = POS_W'((a < b) ? b : a);
               end
               default: begin
                  a = $urandom_range(0, LEAF_COUNT - 1);
                  b = $urandom_range(0, LEAF_COUNT - 1);
                  first = POS_W'((a < b) ? a : b);
                  last  = POS_W'((a < b) ? b : a);
               end
            endcase
         end
         gap = (no_idle || press_left > 0) ? 0 : $urandom_range(0, 5);
         if (press_left > 0) press_left--;
         offer_item(cmd, pos, value, first, last, 1'b0, '0, gap);
      end
      req_valid = 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_sums.size() == 0)
         $display("segment_tree_range_sum_top: match");
      else
         $display("segment_tree_range_sum_top: mismatch");
      $finish;
   end

endmodule
